/* src/psu_pkg.sv */
// Package for the principal strain unit: types, fixed constants, the
// degree atan table and saturation helpers. No dependencies.
package psu_pkg;

  localparam int GUARD = 8;
  localparam int CW = 48;
  localparam int ZW = 35;
  localparam int WW = 72;

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
  localparam logic signed [21:0] SQ3_INV_GAIN_Q20 = 22'sd1102885;
  localparam zval_t DEG180_Q24 = 35'sd3019898880;
  localparam wide_t S32_MAX = 72'sd2147483647;
  localparam wide_t S32_MIN = -72'sd2147483648;
  localparam logic signed [15:0] ANG_LIM = 16'sd23040;
  localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] exy;
    logic signed [32:0] sum;
    cval_t              s0;
    logic               dz;
    logic               ovf;
  } side_t;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] exy;
    logic signed [31:0] major;
    logic signed [31:0] minor;
    logic [30:0]        shear;
    logic signed [15:0] angle;
    logic               ovf;
  } res_t;

  function automatic zval_t atan_q24(logic [4:0] k);
    zval_t r;
    case (k)
      5'd0:  r = 35'sd754974720;
      5'd1:  r = 35'sd445687602;
      5'd2:  r = 35'sd235489088;
      5'd3:  r = 35'sd119537938;
      5'd4:  r = 35'sd60000934;
      5'd5:  r = 35'sd30029717;
      5'd6:  r = 35'sd15018523;
      5'd7:  r = 35'sd7509720;
      5'd8:  r = 35'sd3754917;
      5'd9:  r = 35'sd1877466;
      5'd10: r = 35'sd938734;
      5'd11: r = 35'sd469367;
      5'd12: r = 35'sd234684;
      5'd13: r = 35'sd117342;
      5'd14: r = 35'sd58671;
      5'd15: r = 35'sd29335;
      5'd16: r = 35'sd14668;
      5'd17: r = 35'sd7334;
      5'd18: r = 35'sd3667;
      5'd19: r = 35'sd1833;
      5'd20: r = 35'sd917;
      5'd21: r = 35'sd458;
      5'd22: r = 35'sd229;
      5'd23: r = 35'sd115;
      5'd24: r = 35'sd57;
      5'd25: r = 35'sd29;
      5'd26: r = 35'sd14;
      5'd27: r = 35'sd7;
      5'd28: r = 35'sd4;
      5'd29: r = 35'sd2;
      5'd30: r = 35'sd1;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_s32(wide_t v);
    logic [31:0] r;
    if (v > S32_MAX) r = 32'h7fff_ffff;
    else if (v < S32_MIN) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf_s32(wide_t v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  function automatic logic [30:0] sat_u31(wide_t v);
    logic [30:0] r;
    if (v > S32_MAX) r = 31'h7fff_ffff;
    else if (v < 0) r = 31'h0;
    else r = v[30:0];
    return r;
  endfunction

  function automatic logic ovf_u31(wide_t v);
    return v > S32_MAX;
  endfunction

endpackage

/* src/principal_strain_unit.sv */
// Principal strain unit top level: strain scaling, two pipelined CORDIC
// vectoring chains and result rounding. Depends on psu_pkg.
//
//  channel | ports                              | transfer
//  input   | start, busy, in_grad_*             | start && !busy
//  result  | out_valid, out_*                   | out_valid, one cycle
//  config  | cfg_valid, cfg_ready, cfg_data     | cfg_valid && cfg_ready
//
// One pixel per clock. The pipeline is the two CORDIC chains of one
// micro-rotation per stage plus seven arithmetic stages.
// busy stays low: nothing stalls, results leave on a one-cycle strobe.
// Synchronous reset clears the valid line and sets scale to 1.0.
module principal_strain_unit import psu_pkg::*; #(
  parameter int FRAC_BITS = 24,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_grad_ux,
  input  logic signed [31:0] in_grad_uy,
  input  logic signed [31:0] in_grad_vx,
  input  logic signed [31:0] in_grad_vy,
  output logic               out_valid,
  output logic signed [31:0] out_strain_xx,
  output logic signed [31:0] out_strain_yy,
  output logic signed [31:0] out_strain_xy,
  output logic signed [31:0] out_major_principal,
  output logic signed [31:0] out_minor_principal,
  output logic [30:0]        out_shear_max,
  output logic signed [15:0] out_angle_deg,
  output logic [30:0]        out_equivalent_strain,
  output logic               out_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int N = CORDIC_STEPS;

  logic [31:0] scale_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_data;
    end
  end

  // stage a: products
  logic va_r;
  logic signed [64:0] pux_r, puy_r, pvx_r, pvy_r;
  logic signed [32:0] sc_s;
  assign sc_s = $signed({1'b0, scale_r});

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= start && !busy;
    pux_r <= 65'(in_grad_ux) * 65'(sc_s);
    puy_r <= 65'(in_grad_uy) * 65'(sc_s);
    pvx_r <= 65'(in_grad_vx) * 65'(sc_s);
    pvy_r <= 65'(in_grad_vy) * 65'(sc_s);
  end

  // stage b: strains
  logic vb_r;
  logic signed [31:0] exb_r, eyb_r, exyb_r;
  logic ovfb_r;
  wide_t exw, eyw, exyw;
  logic signed [65:0] shsum;

  always_comb begin
    shsum = 66'(puy_r) + 66'(pvx_r);
    exw = WW'(pux_r >>> FRAC_BITS);
    eyw = WW'(pvy_r >>> FRAC_BITS);
    exyw = WW'(shsum >>> (FRAC_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
    exb_r <= sat_s32(exw);
    eyb_r <= sat_s32(eyw);
    exyb_r <= sat_s32(exyw);
    ovfb_r <= ovf_s32(exw) | ovf_s32(eyw) | ovf_s32(exyw);
  end

  // stage c: inverse gain products
  logic vc_r;
  logic signed [63:0] pd_r, pt_r, ps_r;
  side_t sc_r;
  logic signed [32:0] diff_c, sum_c, twoxy_c;

  always_comb begin
    diff_c = 33'(exb_r) - 33'(eyb_r);
    sum_c = 33'(exb_r) + 33'(eyb_r);
    twoxy_c = 33'(exyb_r) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= vb_r;
    pd_r <= 64'(diff_c) * 64'(INV_GAIN_Q30);
    pt_r <= 64'(twoxy_c) * 64'(INV_GAIN_Q30);
    ps_r <= 64'(sum_c) * 64'(INV_GAIN_Q30);
    sc_r.ex <= exb_r;
    sc_r.ey <= eyb_r;
    sc_r.exy <= exyb_r;
    sc_r.sum <= sum_c;
    sc_r.s0 <= '0;
    sc_r.dz <= (diff_c == 33'sd0);
    sc_r.ovf <= ovfb_r;
  end

  // stage d: guard shift and half-turn pre-rotation
  logic v1_r [0:N];
  cval_t c1x_r [0:N];
  cval_t c1y_r [0:N];
  zval_t c1z_r [0:N];
  side_t s1_r [0:N];
  cval_t x0, y0;
  side_t sd;

  always_comb begin
    x0 = CW'(pd_r >>> (30 - GUARD));
    y0 = CW'(pt_r >>> (30 - GUARD));
    sd = sc_r;
    sd.s0 = CW'(ps_r >>> (30 - GUARD));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r[0] <= 1'b0;
    else v1_r[0] <= vc_r;
    s1_r[0] <= sd;
    if (x0 < 0) begin
      c1x_r[0] <= -x0;
      c1y_r[0] <= -y0;
      c1z_r[0] <= (y0 >= 0) ? DEG180_Q24 : -DEG180_Q24;
    end else begin
      c1x_r[0] <= x0;
      c1y_r[0] <= y0;
      c1z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic1
    always_ff @(posedge clk) begin
      if (!rst_n) v1_r[i+1] <= 1'b0;
      else v1_r[i+1] <= v1_r[i];
      s1_r[i+1] <= s1_r[i];
      if (c1y_r[i] >= 0) begin
        c1x_r[i+1] <= c1x_r[i] + (c1y_r[i] >>> i);
        c1y_r[i+1] <= c1y_r[i] - (c1x_r[i] >>> i);
        c1z_r[i+1] <= c1z_r[i] + atan_q24(5'(i));
      end else begin
        c1x_r[i+1] <= c1x_r[i] - (c1y_r[i] >>> i);
        c1y_r[i+1] <= c1y_r[i] + (c1x_r[i] >>> i);
        c1z_r[i+1] <= c1z_r[i] - atan_q24(5'(i));
      end
    end
  end

  // stage e: Mohr results and sqrt3 product
  logic ve_r;
  res_t re_r;
  logic signed [69:0] pe_r;
  cval_t s0e_r;
  wide_t xfw, shw, tmpw, majw, minw, angw;
  logic signed [15:0] ang_e;
  side_t se;

  always_comb begin
    se = s1_r[N];
    xfw = WW'(c1x_r[N]);
    shw = (xfw + 72'sd128) >>> GUARD;
    tmpw = WW'(se.sum) <<< GUARD;
    majw = (tmpw + xfw + 72'sd256) >>> (GUARD + 1);
    minw = (tmpw - xfw + 72'sd256) >>> (GUARD + 1);
    angw = (WW'(c1z_r[N]) + 72'sd65536) >>> 17;
    if (se.dz) ang_e = '0;
    else if (angw > WW'(ANG_LIM)) ang_e = ANG_LIM;
    else if (angw < -WW'(ANG_LIM)) ang_e = -ANG_LIM;
    else ang_e = angw[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else ve_r <= v1_r[N];
    re_r.ex <= se.ex;
    re_r.ey <= se.ey;
    re_r.exy <= se.exy;
    re_r.major <= sat_s32(majw);
    re_r.minor <= sat_s32(minw);
    re_r.shear <= sat_u31(shw);
    re_r.angle <= ang_e;
    re_r.ovf <= se.ovf | ovf_u31(shw) | ovf_s32(majw) | ovf_s32(minw);
    pe_r <= 70'(c1x_r[N]) * 70'(SQ3_INV_GAIN_Q20);
    s0e_r <= se.s0;
  end

  // stage f: second vector and pre-rotation
  logic v2_r [0:N];
  cval_t c2x_r [0:N];
  cval_t c2y_r [0:N];
  res_t r2_r [0:N];
  cval_t y2;
  assign y2 = CW'(pe_r >>> 20);

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r[0] <= 1'b0;
    else v2_r[0] <= ve_r;
    r2_r[0] <= re_r;
    if (s0e_r < 0) begin
      c2x_r[0] <= -s0e_r;
      c2y_r[0] <= -y2;
    end else begin
      c2x_r[0] <= s0e_r;
      c2y_r[0] <= y2;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic2
    always_ff @(posedge clk) begin
      if (!rst_n) v2_r[i+1] <= 1'b0;
      else v2_r[i+1] <= v2_r[i];
      r2_r[i+1] <= r2_r[i];
      if (c2y_r[i] >= 0) begin
        c2x_r[i+1] <= c2x_r[i] + (c2y_r[i] >>> i);
        c2y_r[i+1] <= c2y_r[i] - (c2x_r[i] >>> i);
      end else begin
        c2x_r[i+1] <= c2x_r[i] - (c2y_r[i] >>> i);
        c2y_r[i+1] <= c2y_r[i] + (c2x_r[i] >>> i);
      end
    end
  end

  // stage g: equivalent strain and output registers
  logic vo_r;
  res_t ro_r;
  logic [30:0] vm_r;
  logic vmo_r;
  wide_t vmw;
  assign vmw = (WW'(c2x_r[N]) + 72'sd256) >>> (GUARD + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else vo_r <= v2_r[N];
    ro_r <= r2_r[N];
    vm_r <= sat_u31(vmw);
    vmo_r <= ovf_u31(vmw);
  end

  assign out_valid = vo_r;
  assign out_strain_xx = ro_r.ex;
  assign out_strain_yy = ro_r.ey;
  assign out_strain_xy = ro_r.exy;
  assign out_major_principal = ro_r.major;
  assign out_minor_principal = ro_r.minor;
  assign out_shear_max = ro_r.shear;
  assign out_angle_deg = ro_r.angle;
  assign out_equivalent_strain = vm_r;
  assign out_overflow = ro_r.ovf | vmo_r;

endmodule

/* src/psu_checker.sv */
// Port-level checks for principal_strain_unit and the bind that attaches
// them. Depends on the top level's port list only.
module psu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic signed [31:0] out_strain_xx,
  input logic signed [31:0] out_strain_yy,
  input logic signed [31:0] out_major_principal,
  input logic signed [31:0] out_minor_principal,
  input logic [30:0]        out_shear_max,
  input logic signed [15:0] out_angle_deg,
  input logic               out_overflow
);

  logic signed [33:0] spread;
  assign spread = 34'(out_major_principal) - 34'(out_minor_principal)
                - 34'($signed({1'b0, out_shear_max}));

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_deg <= 16'sd23040) && (out_angle_deg >= -16'sd23040))
    else $error("angle out of range");

  a_equal_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_strain_xx == out_strain_yy) |-> out_angle_deg == 16'sd0)
    else $error("nonzero angle with equal strains");

  a_mohr_spread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> (spread <= 34'sd2) && (spread >= -34'sd2))
    else $error("principal spread disagrees with max shear");

endmodule

bind principal_strain_unit psu_checker u_psu_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_strain_xx(out_strain_xx),
  .out_strain_yy(out_strain_yy),
  .out_major_principal(out_major_principal),
  .out_minor_principal(out_minor_principal),
  .out_shear_max(out_shear_max),
  .out_angle_deg(out_angle_deg),
  .out_overflow(out_overflow)
);

/* tb/sv/tb_principal_strain_unit.sv */
// Testbench for principal_strain_unit: directed table plus random pixels,
// checked against typed results or an in-bench fixed-point strain and Mohr-circle predictor.
// Depends on psu_pkg and principal_strain_unit.
module tb_principal_strain_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * 24 + 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1600;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] xy;
    logic signed [31:0] major;
    logic signed [31:0] minor;
    logic [30:0]        shear;
    logic signed [15:0] angle;
    logic [30:0]        equiv;
    logic               ovf;
  } strain_res_t;

  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        typed;
    strain_res_t res;
  } pixel_row_t;

  localparam longint INV_GAIN = 652032874;
  localparam longint SQ3_GAIN = 1102885;
  localparam longint HALF_TURN = 64'd3019898880;
  localparam longint ATAN_DEG[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  localparam logic [31:0] ONE = 32'h0100_0000;
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] NEG1 = 32'hff00_0000;

  localparam pixel_row_t DIRECTED[16] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '0},
    '{MAXP, MAXP, MAXP, MAXP, 1'b0, '0},
    '{MINN, MINN, MINN, MINN, 1'b0, '0},
    '{ONE, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{32'h0, 32'h0, 32'h0, ONE, 1'b0, '0},
    '{32'h0, ONE, ONE, 32'h0, 1'b0, '0},
    '{ONE, ONE, 32'h0, ONE, 1'b0, '0},
    '{NEG1, NEG1, NEG1, 32'h0, 1'b0, '0},
    '{NEG1, ONE, 32'h0, 32'h0, 1'b0, '0},
    '{MAXP, 32'h0, 32'h0, MINN, 1'b0, '0},
    '{MINN, 32'h0, 32'h0, MAXP, 1'b0, '0},
    '{32'h0, 32'h1, 32'h0, 32'h0, 1'b0, '0},
    '{32'h0, 32'hffff_ffff, 32'h0, 32'h0, 1'b0, '0},
    '{32'h1, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 1'b0, '0},
    '{MAXP, MINN, MAXP, MINN, 1'b0, '0},
    '{32'h0, MAXP, MINN, 32'h0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_grad_ux = '0;
  logic signed [31:0] in_grad_uy = '0;
  logic signed [31:0] in_grad_vx = '0;
  logic signed [31:0] in_grad_vy = '0;
  logic out_valid;
  logic signed [31:0] out_strain_xx, out_strain_yy, out_strain_xy;
  logic signed [31:0] out_major_principal, out_minor_principal;
  logic [30:0] out_shear_max, out_equivalent_strain;
  logic signed [15:0] out_angle_deg;
  logic out_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  strain_res_t expected_strains[$];
  logic [31:0] pixel_scale;
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  bit driving = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  principal_strain_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_grad_ux(in_grad_ux), .in_grad_uy(in_grad_uy),
    .in_grad_vx(in_grad_vx), .in_grad_vy(in_grad_vy),
    .out_valid(out_valid), .out_strain_xx(out_strain_xx),
    .out_strain_yy(out_strain_yy), .out_strain_xy(out_strain_xy),
    .out_major_principal(out_major_principal),
    .out_minor_principal(out_minor_principal),
    .out_shear_max(out_shear_max), .out_angle_deg(out_angle_deg),
    .out_equivalent_strain(out_equivalent_strain), .out_overflow(out_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic longint clamp_s32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint clamp_u31(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic longint mohr_vector(longint x, longint y, output longint ang);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_DEG[k];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG[k];
      end
    end
    ang = z;
    return x;
  endfunction

  function automatic strain_res_t predict_strains(logic [31:0] ux, logic [31:0] uy,
                                                  logic [31:0] vx, logic [31:0] vy);
    strain_res_t r;
    bit ovf;
    longint sc, p1, p2, half_sum, ex, ey, exy, diff, sum, xf, xf2, ang, tmp;
    longint angle;
    ovf = 1'b0;
    sc = longint'({32'h0, pixel_scale});
    p1 = longint'($signed(uy)) * sc;
    p2 = longint'($signed(vx)) * sc;
    ex = clamp_s32((longint'($signed(ux)) * sc) >>> 24, ovf);
    ey = clamp_s32((longint'($signed(vy)) * sc) >>> 24, ovf);
    half_sum = (p1 >>> 1) + (p2 >>> 1) + ((p1 & 1) + (p2 & 1)) / 2;
    exy = clamp_s32(half_sum >>> 24, ovf);
    diff = ex - ey;
    sum = ex + ey;
    xf = mohr_vector((diff * INV_GAIN) >>> 22, (2 * exy * INV_GAIN) >>> 22, ang);
    r.shear = 31'(clamp_u31((xf + 128) >>> 8, ovf));
    tmp = sum * 256;
    r.major = 32'(clamp_s32((tmp + xf + 256) >>> 9, ovf));
    r.minor = 32'(clamp_s32((tmp - xf + 256) >>> 9, ovf));
    if (diff == 0) begin
      angle = 0;
    end else begin
      angle = (ang + 65536) >>> 17;
      if (angle > 23040) angle = 23040;
      if (angle < -23040) angle = -23040;
    end
    r.angle = 16'(angle);
    xf2 = mohr_vector((sum * INV_GAIN) >>> 22, (xf * SQ3_GAIN) >>> 20, tmp);
    r.equiv = 31'(clamp_u31((xf2 + 256) >>> 9, ovf));
    r.xx = 32'(ex);
    r.yy = 32'(ey);
    r.xy = 32'(exy);
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    strain_res_t got;
    strain_res_t want;
    if (rst_n && out_valid) begin
      got = '{out_strain_xx, out_strain_yy, out_strain_xy, out_major_principal,
              out_minor_principal, out_shear_max, out_angle_deg,
              out_equivalent_strain, out_overflow};
      if (expected_strains.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_strains.pop_front();
        if (got.xx !== want.xx || got.yy !== want.yy || got.xy !== want.xy ||
            got.major !== want.major || got.minor !== want.minor ||
            got.shear !== want.shear || got.angle !== want.angle ||
            got.equiv !== want.equiv || got.ovf !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p\n         act %p", want, got);
        end
      end
    end
  end

  task automatic send_pixel(logic [31:0] ux, logic [31:0] uy, logic [31:0] vx,
                            logic [31:0] vy, bit typed, strain_res_t typed_res);
    start <= 1'b1;
    driving = 1'b1;
    in_grad_ux <= ux;
    in_grad_uy <= uy;
    in_grad_vx <= vx;
    in_grad_vy <= vy;
    do @(posedge clk); while (busy);
    expected_strains.push_back(typed ? typed_res : predict_strains(ux, uy, vx, vy));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      driving = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic drain;
    if (driving) begin
      start <= 1'b0;
      driving = 1'b0;
      @(posedge clk);
    end
    while (expected_strains.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    pixel_scale = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_grad();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom()) >>> $urandom_range(4, 30));
      2: return 32'($signed($urandom()) >>> 24);
      default: return $urandom_range(0, 1) ? $urandom_range(0, 8) : -$urandom_range(0, 8);
    endcase
  endfunction

  initial begin
    logic [31:0] phase_scale[8];
    logic [31:0] g;
    pixel_scale = ONE;
    phase_scale = '{ONE, 32'h0, 32'hffff_ffff, 32'h1, 32'h0010_0000,
                    32'h8000_0000, 32'h0, 32'h0};
    phase_scale[6] = $urandom();
    phase_scale[7] = $urandom_range(32'h0080_0000, 32'h0400_0000);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i].ux, DIRECTED[i].uy, DIRECTED[i].vx, DIRECTED[i].vy,
                 DIRECTED[i].typed, DIRECTED[i].res);
    for (int p = 0; p < 8; p++) begin
      write_scale(phase_scale[p]);
      for (int n = 0; n < N_RANDOM / 8; n++) begin
        g = random_grad();
        if ($urandom_range(0, 9) == 0)
          send_pixel(g, random_grad(), random_grad(), g, 1'b0, '0);
        else
          send_pixel(random_grad(), random_grad(), random_grad(), random_grad(), 1'b0, '0);
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/psu_pkg.sv
src/principal_strain_unit.sv
src/psu_checker.sv
tb/sv/tb_principal_strain_unit.sv
